/* rtl/core/sha_pkg.sv */
// ---------------------------------------------------------------------------
// sha_pkg
// shared types and constants for the byte-stream sha-256 engine
// ---------------------------------------------------------------------------
package sha_pkg;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ABSORB,
        CMD_PAD,
        CMD_START,
        CMD_FOLD,
        CMD_RESTART
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t   code;
        logic        pad_zero;
        logic        bump_len;
        logic [5:0]  pad_pos;
    } dp_cmd_t;

    typedef struct packed {
        logic        round_done;
        logic [5:0]  fill;
    } dp_stat_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
        rotr = (v >> s) | (v << (32 - s));
    endfunction

endpackage

/* rtl/core/sha256_byte_stream_hasher.sv */
// ---------------------------------------------------------------------------
// sha256_byte_stream_hasher
// sha-256 engine taking one message byte per item, digest as eight words
// ---------------------------------------------------------------------------
// an absorb item is taken while idle; every 64th byte starts a compression
// (loading the 16-word schedule window from the byte buffer, 64 single
// rounds of the shared round unit, control steps), during which input is
// held off. a finish item pads one byte per cycle up to the block end,
// compresses once or twice, then offers the eight digest words.
module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word, word_index, zero fill
    output logic        m_tlast    // last_word
);
    import sha_pkg::*;

    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic [2:0] idx;
    logic [31:0] word;

    sha_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (idx),
        .cmd       (cmd),
        .stat      (stat)
    );

    sha_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .byte_value (s_tdata),
        .rd_index   (idx),
        .rd_word    (word),
        .stat       (stat)
    );

    assign m_tdata = {5'd0, idx, word};
    assign m_tlast = (idx == 3'd7);

endmodule

/* rtl/core/sha_datapath.sv */
// ---------------------------------------------------------------------------
// sha_datapath
// block buffer, message schedule window, round unit and chaining words
// ---------------------------------------------------------------------------
module sha_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::dp_cmd_t  cmd,
    input  logic [7:0]        byte_value,
    input  logic [2:0]        rd_index,
    output logic [31:0]       rd_word,
    output sha_pkg::dp_stat_t stat
);
    import sha_pkg::*;

    // block buffer kept as 16 big-endian words, byte lanes written singly
    logic [31:0] buf_mem [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  rnd_reg;
    logic        busy_reg;

    // loading the window reads one word per cycle
    logic [3:0]  ld_reg;
    logic        ld_busy_reg;
    logic [31:0] ld_word_reg;
    logic        ld_dly_reg;

    logic [31:0] w_new, x1, x2, wt;
    logic [63:0] len_next;

    assign len_next = len_reg + {55'd0, fill_reg, 3'd0};

    // schedule extension for word t+16 and the round terms
    always_comb
    begin
        w_new = (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10))
              + w_reg[9]
              + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
              + w_reg[0];
        wt = w_reg[0];
        x1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[rnd_reg] + wt;
        x2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // buffer writes; padding fills one byte a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.code == CMD_ABSORB)
        begin
            buf_mem[fill_reg[5:2]][{~fill_reg[1:0], 3'd0} +: 8] <= byte_value;
        end
        else if (cmd.code == CMD_PAD)
        begin
            if (cmd.pad_pos >= LEN_POS && cmd.bump_len)
            begin
                buf_mem[cmd.pad_pos[5:2]][{~cmd.pad_pos[1:0], 3'd0} +: 8] <=
                    len_reg[8*(6'd63 - cmd.pad_pos) +: 8];
            end
            else
            begin
                buf_mem[cmd.pad_pos[5:2]][{~cmd.pad_pos[1:0], 3'd0} +: 8] <=
                    cmd.pad_zero ? 8'h00 : PAD_BYTE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            len_reg     <= '0;
            rnd_reg     <= '0;
            busy_reg    <= 1'b0;
            ld_reg      <= '0;
            ld_busy_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_H[i];
            end
        end
        else
        begin
            unique case (cmd.code)
                CMD_ABSORB:
                begin
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        len_reg <= len_reg + 64'd512;
                    end
                end
                CMD_PAD:
                begin
                    if (cmd.pad_pos == fill_reg && !cmd.pad_zero)
                    begin
                        len_reg <= len_next;
                    end
                end
                CMD_START:
                begin
                    ld_reg      <= '0;
                    ld_busy_reg <= 1'b1;
                end
                CMD_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
                CMD_RESTART:
                begin
                    fill_reg <= '0;
                    len_reg  <= '0;
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= INIT_H[i];
                    end
                end
                default:
                begin
                end
            endcase
            if (ld_busy_reg)
            begin
                ld_reg <= ld_reg + 4'd1;
                if (ld_reg == 4'd15)
                begin
                    ld_busy_reg <= 1'b0;
                end
            end
            else if (ld_dly_reg)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // word reads for the window, one word per cycle over a shift
    always_ff @(posedge clk)
    begin
        ld_word_reg <= buf_mem[ld_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_dly_reg <= 1'b0;
        end
        else
        begin
            ld_dly_reg <= ld_busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.code == CMD_START)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        if (ld_dly_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= ld_word_reg;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + x1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= x1 + x2;
        end
    end

    // rounds start on the edge after the last loaded word lands in the window
    assign stat.round_done = !busy_reg && !ld_busy_reg && !ld_dly_reg;
    assign stat.fill       = fill_reg;
    assign rd_word         = h_reg[rd_index];

endmodule

/* rtl/core/sha_control.sv */
// ---------------------------------------------------------------------------
// sha_control
// sequencer for absorb, padding, compression and digest output
// ---------------------------------------------------------------------------
module sha_control (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        out_index,
    output sha_pkg::dp_cmd_t  cmd,
    input  sha_pkg::dp_stat_t stat
);
    import sha_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PAD, ST_START, ST_WAIT, ST_SETTLE, ST_FOLD, ST_EMIT, ST_RESTART
    } state_t;

    state_t     state_reg;
    logic [5:0] pos_reg;
    logic       zero_reg;
    logic       final_reg;
    logic       finish_reg;
    logic [2:0] idx_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign out_index = idx_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.code     = CMD_NONE;
        cmd.pad_pos  = pos_reg;
        cmd.pad_zero = zero_reg;
        cmd.bump_len = final_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_op)
                begin
                    cmd.code = CMD_ABSORB;
                end
            end
            ST_PAD:    cmd.code = CMD_PAD;
            ST_START:  cmd.code = CMD_START;
            ST_FOLD:   cmd.code = CMD_FOLD;
            ST_RESTART: cmd.code = CMD_RESTART;
            default:   cmd.code = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            zero_reg   <= 1'b0;
            final_reg  <= 1'b0;
            finish_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_op)
                        begin
                            state_reg  <= ST_PAD;
                            pos_reg    <= stat.fill;
                            zero_reg   <= 1'b0;
                            final_reg  <= (stat.fill < LEN_POS);
                            finish_reg <= 1'b1;
                        end
                        else if (stat.fill == 6'd63)
                        begin
                            state_reg  <= ST_START;
                            finish_reg <= 1'b0;
                        end
                    end
                end
                ST_PAD:
                begin
                    zero_reg <= 1'b1;
                    pos_reg  <= pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                    begin
                        state_reg <= ST_START;
                    end
                end
                ST_START:  state_reg <= ST_WAIT;
                ST_WAIT:   state_reg <= ST_SETTLE;
                ST_SETTLE:
                begin
                    if (stat.round_done)
                    begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD:
                begin
                    if (!finish_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (!final_reg)
                    begin
                        state_reg <= ST_PAD;
                        pos_reg   <= '0;
                        zero_reg  <= 1'b1;
                        final_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_EMIT;
                        idx_reg   <= '0;
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            state_reg <= ST_RESTART;
                        end
                    end
                end
                ST_RESTART:
                begin
                    state_reg  <= ST_IDLE;
                    finish_reg <= 1'b0;
                    final_reg  <= 1'b0;
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("digest shown while taking input");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> final_reg && finish_reg)
        else $error("digest without final block");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |-> stat.round_done)
        else $error("fold before rounds finished");

endmodule

/* verif/tb_sha256_byte_stream_hasher.sv */
// ---------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher
// byte-stream sha-256 engine checked against a behavioral digest predictor
// ---------------------------------------------------------------------------
// message bytes and finish items go in on the slave side with random gaps;
// every finish queues eight expected digest words, which are compared in
// order with the master side under random back-pressure
module tb_sha256_byte_stream_hasher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit OP_ABSORB = 1'b0;
    localparam bit OP_FINISH = 1'b1;
    localparam int DIRECTED_ROWS = 12;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    typedef struct {
        bit       op;
        bit [7:0] value;
        bit       known;
        bit [31:0] word0;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    logic [31:0] chain [8];
    logic [7:0]  msg_block [64];
    logic [5:0]  fill;
    logic [63:0] bit_total;
    digest_word_t digest_q [$];
    int          fail_count = 0;
    bit          stim_done = 1'b0;

    sha256_byte_stream_hasher dut (.*);

    always #4 clk = ~clk;

    function automatic logic [31:0] ror(input logic [31:0] v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        v = chain;
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] += v[i];
    endtask

    task automatic restart_hash();
        chain = sha_pkg::INIT_H;
        fill = '0;
        bit_total = '0;
    endtask

    task automatic predict_digest(input bit op, input logic [7:0] value);
        int j;
        digest_word_t d;
        if (op == OP_ABSORB)
        begin
            msg_block[fill] = value;
            fill++;
            if (fill == 0)
            begin
                compress_block();
                bit_total += 512;
            end
            return;
        end
        j = fill;
        bit_total += 64'(j) * 8;
        msg_block[j++] = sha_pkg::PAD_BYTE;
        if (j > 56)
        begin
            while (j < 64) msg_block[j++] = '0;
            compress_block();
            j = 0;
        end
        while (j < 56) msg_block[j++] = '0;
        for (int n = 0; n < 8; n++)
            msg_block[63-n] = bit_total[8*n +: 8];
        compress_block();
        for (int n = 0; n < 8; n++)
        begin
            d.word = chain[n];
            d.index = 3'(n);
            d.last = (n == 7);
            digest_q = {digest_q, d};
        end
        restart_hash();
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    task automatic send_item(input bit op, input logic [7:0] value);
        repeat (gap_len()) @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = value;
        do @(posedge clk); while (!s_tready);
        predict_digest(op, value);
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tdata = 8'($urandom);
    endtask

    task automatic wait_drained();
        while (digest_q.size() != 0) @(negedge clk);
    endtask

    // directed rows: empty message, "abc", byte extremes, a two-byte message
    stim_row_t directed [DIRECTED_ROWS] = '{
        '{OP_FINISH, 8'h00, 1'b1, 32'he3b0c442},
        '{OP_ABSORB, 8'h61, 1'b0, 32'h0},
        '{OP_ABSORB, 8'h62, 1'b0, 32'h0},
        '{OP_ABSORB, 8'h63, 1'b0, 32'h0},
        '{OP_FINISH, 8'hff, 1'b1, 32'hba7816bf},
        '{OP_ABSORB, 8'h00, 1'b0, 32'h0},
        '{OP_FINISH, 8'h00, 1'b0, 32'h0},
        '{OP_ABSORB, 8'hff, 1'b0, 32'h0},
        '{OP_FINISH, 8'h00, 1'b0, 32'h0},
        '{OP_ABSORB, 8'h55, 1'b0, 32'h0},
        '{OP_ABSORB, 8'haa, 1'b0, 32'h0},
        '{OP_FINISH, 8'h00, 1'b0, 32'h0}
    };

    // sink side with random stalls
    always @(negedge clk)
        m_tready <= stim_done ? ($urandom_range(0, 3) != 0) : (gap_len() == 0);

    always @(posedge clk)
    begin
        digest_word_t exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_q.size() == 0)
            begin
                $error("digest word with nothing expected: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                exp_w = digest_q.pop_front();
                if (m_tdata[31:0] !== exp_w.word)
                begin
                    $error("digest_word exp %h got %h", exp_w.word, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[34:32] !== exp_w.index)
                begin
                    $error("word_index exp %0d got %0d", exp_w.index, m_tdata[34:32]);
                    fail_count++;
                end
                if (m_tlast !== exp_w.last)
                begin
                    $error("last_word exp %0b got %0b", exp_w.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int len;
        restart_hash();
        for (int i = 0; i < 64; i++) msg_block[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[r])
        begin
            if (directed[r].known && directed[r].op == OP_FINISH)
            begin
                send_item(directed[r].op, directed[r].value);
                if (digest_q[0].word !== directed[r].word0)
                begin
                    $error("digest_word exp %h got %h", directed[r].word0, digest_q[0].word);
                    fail_count++;
                end
            end
            else
                send_item(directed[r].op, directed[r].value);
        end
        wait_drained();

        // message lengths around the 55/56/64 padding edges, then random
        for (int k = 0; k < 4; k++)
        begin
            len = (k == 0) ? 55 : (k == 1) ? 56 : (k == 2) ? 63 : 64;
            for (int i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom));
            send_item(OP_FINISH, 8'($urandom));
        end
        wait_drained();

        for (int n = 0; n < 70; )
        begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 12);
            for (int i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom));
            send_item(OP_FINISH, 8'($urandom));
            n += len + 1;
            if (n > 30 && n < 50) wait_drained();
        end

        stim_done = 1'b1;
        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/sha_pkg.sv
rtl/core/sha_datapath.sv
rtl/core/sha_control.sv
rtl/core/sha256_byte_stream_hasher.sv
verif/tb_sha256_byte_stream_hasher.sv
